### rtl/core/dnsl_pkg.sv
// Shared types and constants for the DNS header and name decoder.
package dnsl_pkg;

    localparam int HEADER_BYTES    = 12;
    localparam int QUEUE_DEPTH_DEF = 4;
    localparam int TDATA_W         = 24;
    localparam logic [7:0] DOT_CHAR = 8'h2E;

    typedef enum logic [1:0] {
        KIND_WORD = 2'd0,
        KIND_CHAR = 2'd1,
        KIND_END  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        PH_HEADER = 3'b001,
        PH_NAME   = 3'b010,
        PH_SKIP   = 3'b100
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [2:0]  slot;
        logic [15:0] value;
        logic        status;
    } res_t;

    // one queue entry: the results of one byte (one or two)
    typedef struct packed {
        logic two;
        res_t r0;
        res_t r1;
    } job_t;

endpackage

### rtl/core/dnsl_front.sv
// Front end: takes packet bytes, tracks parse state, builds result jobs.
module dnsl_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,   // [7:0] pkt_byte
    input  logic          s_axis_tlast,
    input  logic          q_full,
    output logic          q_push,
    output dnsl_pkg::job_t q_job
);
    import dnsl_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [3:0]  hpos_reg, hpos_next;
    logic [7:0]  hold_reg, hold_next;
    logic [7:0]  left_reg, left_next;
    logic        first_reg, first_next;

    logic        accept;
    logic        main_vld;
    logic        end_vld;
    logic        name_open;
    res_t        main_res;
    res_t        end_res;

    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && !q_full;

    always_comb
    begin
        phase_next = phase_reg;
        hpos_next  = hpos_reg;
        hold_next  = hold_reg;
        left_next  = left_reg;
        first_next = first_reg;
        main_vld   = 1'b0;
        main_res   = '0;
        name_open  = 1'b0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (!hpos_reg[0])
                begin
                    hold_next = s_axis_tdata;
                end
                else
                begin
                    main_vld       = 1'b1;
                    main_res.kind  = KIND_WORD;
                    main_res.slot  = hpos_reg[3:1];
                    main_res.value = {hold_reg, s_axis_tdata};
                end
                hpos_next = hpos_reg + 4'd1;
                if (hpos_reg == 4'(HEADER_BYTES - 1))
                begin
                    phase_next = PH_NAME;
                    left_next  = '0;
                    first_next = 1'b1;
                end
                name_open = 1'b1;
            end
            PH_NAME:
            begin
                if (left_reg == 8'd0)
                begin
                    if (s_axis_tdata == 8'd0)
                    begin
                        main_vld      = 1'b1;
                        main_res.kind = KIND_END;
                        phase_next    = PH_SKIP;
                    end
                    else
                    begin
                        left_next = s_axis_tdata;
                        if (!first_reg)
                        begin
                            main_vld       = 1'b1;
                            main_res.kind  = KIND_CHAR;
                            main_res.value = {8'd0, DOT_CHAR};
                        end
                        first_next = 1'b0;
                        name_open  = 1'b1;
                    end
                end
                else
                begin
                    main_vld       = 1'b1;
                    main_res.kind  = KIND_CHAR;
                    main_res.value = {8'd0, s_axis_tdata};
                    left_next      = left_reg - 8'd1;
                    name_open      = 1'b1;
                end
            end
            default: ;
        endcase

        end_vld        = s_axis_tlast && name_open;
        end_res        = '0;
        end_res.kind   = KIND_END;
        end_res.status = 1'b1;

        // end of packet: back to the reset state
        if (s_axis_tlast)
        begin
            phase_next = PH_HEADER;
            hpos_next  = '0;
            hold_next  = '0;
            left_next  = '0;
            first_next = 1'b1;
        end

        q_push = accept && (main_vld || end_vld);
        if (main_vld)
        begin
            q_job.two = end_vld;
            q_job.r0  = main_res;
            q_job.r1  = end_res;
        end
        else
        begin
            q_job.two = 1'b0;
            q_job.r0  = end_res;
            q_job.r1  = end_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            hpos_reg  <= '0;
            hold_reg  <= '0;
            left_reg  <= '0;
            first_reg <= 1'b1;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
            hold_reg  <= hold_next;
            left_reg  <= left_next;
            first_reg <= first_next;
        end
    end

endmodule

### rtl/core/dnsl_queue.sv
// Small register FIFO of result jobs between front and back end.
module dnsl_queue #(
    parameter int DEPTH = dnsl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dnsl_pkg::job_t din,
    input  logic           pop,
    output dnsl_pkg::job_t dout,
    output logic           full,
    output logic           empty
);
    import dnsl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_push;
    logic          do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

### rtl/core/dnsl_back.sv
// Back end: unpacks jobs into single results behind an output register.
module dnsl_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         q_empty,
    input  dnsl_pkg::job_t               q_head,
    output logic                         q_pop,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [dnsl_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]                   m_axis_tuser,
    output logic                         m_axis_tlast
);
    import dnsl_pkg::*;

    logic  out_vld_reg, out_vld_next;
    logic  second_reg, second_next;
    res_t  res_reg;
    logic  last_reg;
    res_t  res_sel;
    logic  last_sel;
    logic  load;

    assign load = (!out_vld_reg || m_axis_tready) && !q_empty;

    always_comb
    begin
        q_pop        = 1'b0;
        second_next  = second_reg;
        out_vld_next = out_vld_reg && !m_axis_tready;
        res_sel      = q_head.r0;
        last_sel     = !q_head.two;
        if (load)
        begin
            out_vld_next = 1'b1;
            if (second_reg)
            begin
                res_sel     = q_head.r1;
                last_sel    = 1'b1;
                q_pop       = 1'b1;
                second_next = 1'b0;
            end
            else if (q_head.two)
            begin
                second_next = 1'b1;
            end
            else
            begin
                q_pop = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
            second_reg  <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
            second_reg  <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg  <= res_sel;
            last_reg <= last_sel;
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {4'd0, res_reg.status, res_reg.value, res_reg.slot};
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tlast  = last_reg;

endmodule

### rtl/core/dns_name_label_decoder.sv
// Top level of the DNS header and first-name decoder.
// Throughput: one packet byte per cycle while the job queue is not full;
// results leave at one beat per cycle while the receiver is ready. Results
// pass through the job queue (QUEUE_DEPTH entries), then the output register.
// A byte with a result and an early end needs two beats; the queue absorbs it.
// Reset: async active low; parser back in header phase, queue and output empty.
module dns_name_label_decoder #(
    parameter int QUEUE_DEPTH = dnsl_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // input stream: one packet byte per beat
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [7:0] pkt_byte
    input  logic                         s_axis_tlast,   // end_of_packet
    // result stream
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // [2:0] header_slot, [18:3] res_value, [19] status, [23:20] zero
    output logic [dnsl_pkg::TDATA_W-1:0] m_axis_tdata,
    output logic [1:0]                   m_axis_tuser,   // [1:0] res_kind
    output logic                         m_axis_tlast    // last_of_run
);
    import dnsl_pkg::*;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    job_t q_din;
    job_t q_head;

    // Front: header word assembly and label walk; one byte per cycle,
    // stalls only when the job queue is full.
    dnsl_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (q_din)
    );

    // Jobs hold one or two results; bytes with no result push nothing.
    dnsl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_head),
        .full  (q_full),
        .empty (q_empty)
    );

    // Back: serializes each job into beats, tlast on the final one.
    dnsl_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

### rtl/core/dnsl_checker.sv
// Port-level assertions for the decoder, bound to the top level.
module dnsl_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [dnsl_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic [1:0]                   m_axis_tuser,
    input logic                         m_axis_tlast
);
    import dnsl_pkg::*;

    // stalled beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result beat changed while stalled");

    // end of name always closes the run of its byte
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_END |-> m_axis_tlast)
        else $error("end result without tlast");

    // truncated status only on end results
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[19] |-> m_axis_tuser == KIND_END)
        else $error("status set on non-end result");

    // characters carry one byte and no slot
    a_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_CHAR |->
            m_axis_tdata[18:11] == 8'd0 && m_axis_tdata[2:0] == 3'd0)
        else $error("malformed character result");

    // header slots stay within the six words
    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_WORD |-> m_axis_tdata[2:0] <= 3'd5)
        else $error("header slot out of range");

endmodule

bind dns_name_label_decoder dnsl_checker u_dnsl_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for dns_name_label_decoder: directed and random packets, scored per beat.
module tb_top;
    import dnsl_pkg::*;

    localparam int WATCHDOG_CYCLES = 3000;
    localparam int HOLD_CYCLES     = 300;
    localparam int DRAIN_CYCLES    = 20;

    // one expected output beat
    typedef struct {
        kind_t       kind;
        logic [2:0]  slot;
        logic [15:0] value;
        logic        status;
        logic        last;
    } name_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata = 8'h00;
    logic                s_axis_tlast = 1'b0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]  m_axis_tdata;
    logic [1:0]          m_axis_tuser;
    logic                m_axis_tlast;

    // decoder state mirror
    phase_t      mdl_phase;
    logic [3:0]  mdl_header_pos;
    logic [7:0]  mdl_high_byte;
    logic [7:0]  mdl_label_left;
    logic        mdl_first_label;

    name_result_t pending_results[$];
    logic [7:0]   pkt_bytes[$];

    bit   gaps_on = 1'b1;
    logic rx_hold = 1'b0;
    event start_hold;
    int   err_cnt = 0;
    int   bytes_sent = 0;
    int   beats_checked = 0;
    int   packets_sent = 0;
    int   packets_cut = 0;
    int   quiet_cycles = 0;

    dns_name_label_decoder dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void clear_decoder_state();
        mdl_phase       = PH_HEADER;
        mdl_header_pos  = '0;
        mdl_high_byte   = '0;
        mdl_label_left  = '0;
        mdl_first_label = 1'b1;
    endfunction

    // Works out the beats caused by one accepted byte and queues them.
    function automatic void decode_packet_byte(logic [7:0] b, logic eop);
        name_result_t res[2];
        int           n;
        bit           name_open;
        n = 0;
        name_open = 1'b0;
        for (int i = 0; i < 2; i++)
        begin
            res[i] = '{KIND_WORD, 3'd0, 16'd0, 1'b0, 1'b0};
        end
        case (mdl_phase)
            PH_HEADER:
            begin
                if (!mdl_header_pos[0])
                begin
                    mdl_high_byte = b;
                end
                else
                begin
                    res[n].kind  = KIND_WORD;
                    res[n].slot  = mdl_header_pos[3:1];
                    res[n].value = {mdl_high_byte, b};
                    n++;
                end
                mdl_header_pos = mdl_header_pos + 4'd1;
                if (mdl_header_pos >= HEADER_BYTES)
                begin
                    mdl_phase       = PH_NAME;
                    mdl_label_left  = '0;
                    mdl_first_label = 1'b1;
                end
                name_open = 1'b1;
            end
            PH_NAME:
            begin
                if (mdl_label_left == 0)
                begin
                    if (b == 8'd0)
                    begin
                        res[n].kind = KIND_END;
                        n++;
                        mdl_phase = PH_SKIP;
                    end
                    else
                    begin
                        mdl_label_left = b;
                        // dot separates labels
                        if (!mdl_first_label)
                        begin
                            res[n].kind  = KIND_CHAR;
                            res[n].value = {8'd0, DOT_CHAR};
                            n++;
                        end
                        mdl_first_label = 1'b0;
                        name_open = 1'b1;
                    end
                end
                else
                begin
                    res[n].kind  = KIND_CHAR;
                    res[n].value = {8'd0, b};
                    n++;
                    mdl_label_left = mdl_label_left - 8'd1;
                    name_open = 1'b1;
                end
            end
            default:
            begin
                // past the name: nothing until end of packet
            end
        endcase
        if (eop)
        begin
            // truncated name gets a closing beat with status set
            if (name_open)
            begin
                res[n].kind   = KIND_END;
                res[n].status = 1'b1;
                n++;
            end
            clear_decoder_state();
        end
        if (n > 0)
        begin
            res[n-1].last = 1'b1;
        end
        for (int i = 0; i < n; i++)
        begin
            pending_results.push_back(res[i]);
        end
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            err_cnt++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    function automatic void score_beat();
        name_result_t want;
        if (pending_results.size() == 0)
        begin
            err_cnt++;
            $display("%0t: unexpected beat: expected none, actual kind %0h data %0h",
                     $time, m_axis_tuser, m_axis_tdata);
            return;
        end
        want = pending_results.pop_front();
        beats_checked++;
        check_field("res_kind", want.kind, m_axis_tuser);
        check_field("header_slot", want.slot, m_axis_tdata[2:0]);
        check_field("res_value", want.value, m_axis_tdata[18:3]);
        check_field("status", want.status, m_axis_tdata[19]);
        check_field("tdata pad", 0, m_axis_tdata[TDATA_W-1:20]);
        check_field("last_of_run", want.last, m_axis_tlast);
    endfunction

    // result side: score accepted beats, then pick next tready
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                score_beat();
            end
            m_axis_tready <= !rx_hold && !(gaps_on && $urandom_range(0, 99) < 11);
        end
    end

    // long receiver hold-off, counted here
    initial
    begin
        forever
        begin
            @(start_hold);
            rx_hold <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            rx_hold <= 1'b0;
        end
    end

    // watchdog: too long with no beat moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= WATCHDOG_CYCLES)
            begin
                $display("%0t: watchdog expired, %0d beats outstanding",
                         $time, pending_results.size());
                $display("** dns_name_label_decoder: FAILED **");
                $finish;
            end
        end
    end

    // Offers one byte, with random gaps, and waits for it to be taken.
    task automatic send_byte(logic [7:0] b, logic eop);
        while (gaps_on && $urandom_range(0, 99) < 11)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eop;
        do
            @(posedge clk);
        while (!s_axis_tready);
        bytes_sent++;
        decode_packet_byte(b, eop);
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_bytes.size(); i++)
        begin
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
        end
        packets_sent++;
    endtask

    // Random header, one to four labels, terminator, a few trailing bytes;
    // optionally cut short anywhere.
    task automatic make_packet(bit cut_short);
        int n_labels;
        int len;
        int keep;
        pkt_bytes = {};
        repeat (HEADER_BYTES) pkt_bytes.push_back(8'($urandom_range(0, 255)));
        n_labels = $urandom_range(1, 4);
        repeat (n_labels)
        begin
            // mostly short labels, now and then a long one
            len = ($urandom_range(0, 29) == 0) ? $urandom_range(9, 255) : $urandom_range(1, 8);
            pkt_bytes.push_back(8'(len));
            repeat (len) pkt_bytes.push_back(8'($urandom_range(0, 255)));
        end
        pkt_bytes.push_back(8'd0);
        repeat ($urandom_range(0, 3)) pkt_bytes.push_back(8'($urandom_range(0, 255)));
        if (cut_short)
        begin
            keep = $urandom_range(1, pkt_bytes.size() - 1);
            while (pkt_bytes.size() > keep)
            begin
                void'(pkt_bytes.pop_back());
            end
            packets_cut++;
        end
    endtask

    task automatic send_random_packets(int n_bytes);
        int stop_at;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            make_packet($urandom_range(0, 99) < 20);
            send_packet();
        end
    endtask

    // Extreme header words, zero byte inside a label, dot between labels,
    // trailing byte after the name.
    task automatic test_directed_header_and_name();
        pkt_bytes = {8'h00, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'h01, 8'h80, 8'h00,
                     8'h7F, 8'hFF, 8'h12, 8'h34,
                     8'h01, 8'h00, 8'h02, 8'hFF, 8'h41, 8'h00, 8'hFF};
        send_packet();
    endtask

    // Packets that end in the header: on a word boundary, and a lone byte.
    task automatic test_early_ends();
        pkt_bytes = {8'hAB, 8'hCD};
        send_packet();
        pkt_bytes = {8'h5A};
        send_packet();
        packets_cut += 2;
    endtask

    task automatic test_random_packets();
        send_random_packets(650);
    endtask

    task automatic test_long_burst();
        gaps_on = 1'b0;
        send_random_packets(100);
        gaps_on = 1'b1;
    endtask

    // Receiver stops while the sender keeps offering, so the queue fills.
    task automatic test_output_backpressure();
        -> start_hold;
        send_random_packets(80);
    endtask

    initial
    begin
        clear_decoder_state();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_header_and_name();
        test_early_ends();
        test_random_packets();
        test_long_burst();
        test_output_backpressure();

        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d bytes in %0d packets (%0d ended early), %0d result beats scored,",
                 bytes_sent, packets_sent, packets_cut, beats_checked);
        $display("with random gaps, a gap-free burst and a %0d-cycle receiver hold-off.",
                 HOLD_CYCLES);
        if (err_cnt == 0)
        begin
            $display("** dns_name_label_decoder: PASSED **");
        end
        else
        begin
            $display("** dns_name_label_decoder: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/dnsl_pkg.sv
rtl/core/dnsl_front.sv
rtl/core/dnsl_queue.sv
rtl/core/dnsl_back.sv
rtl/core/dns_name_label_decoder.sv
rtl/core/dnsl_checker.sv
tb/sv/tb_top.sv
